// File: rtl/kmq_pkg.sv
// Shared types, state codes and key code tables for the keyboard matrix key queue.
// No dependencies.
package kmq_pkg;

	// Sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MODE  = 6'b000010,
		ST_PRESS = 6'b000100,
		ST_REL   = 6'b001000,
		ST_DROP  = 6'b010000,
		ST_EMIT  = 6'b100000
	} seq_state_t;

	// Command from the sequencer to the key ring
	typedef struct packed {
		logic       clear;
		logic       push;
		logic       pop;
		logic [7:0] data;
	} ring_cmd_t;

	localparam logic [1:0] MODE_NORMAL     = 2'b00;
	localparam logic [1:0] MODE_SHIFT      = 2'b01;
	localparam logic [1:0] MODE_KANA       = 2'b10;
	localparam logic [1:0] MODE_KANA_SHIFT = 2'b11;

	localparam int LEN_NORMAL = 82;
	localparam int LEN_OTHER  = 80;
	localparam int LEN_GRAPH  = 64;

	localparam logic [7:0] TAB_NORMAL [LEN_NORMAL] = '{
		8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,
		8'h38,8'h39,8'h2a,8'h2b,8'h3d,8'h2c,8'h2e,8'h0d,
		8'h5b,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,
		8'h68,8'h69,8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,8'h6f,
		8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,8'h76,8'h77,
		8'h78,8'h79,8'h7a,8'h5d,8'h3f,8'h5c,8'h3d,8'h2d,
		8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,
		8'h38,8'h39,8'h27,8'h3b,8'h2c,8'h2e,8'h2f,8'h00,
		8'h0c,8'h1e,8'h1c,8'h08,8'h00,8'h00,8'h00,8'h00,
		8'h03,8'h00,8'h00,8'h00,8'h00,8'h00,8'h20,8'h1b,
		8'h1f,8'h1d
	};

	localparam logic [7:0] TAB_SHIFT [LEN_OTHER] = '{
		8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,
		8'h38,8'h39,8'h2a,8'h2b,8'h3d,8'h2c,8'h2e,8'h0d,
		8'h7b,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,
		8'h48,8'h49,8'h4a,8'h4b,8'h4c,8'h4d,8'h4e,8'h4f,
		8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
		8'h58,8'h59,8'h5a,8'h7d,8'h00,8'h7c,8'h2b,8'h5f,
		8'h29,8'h21,8'h40,8'h23,8'h24,8'h25,8'h5e,8'h26,
		8'h2a,8'h28,8'h22,8'h3a,8'h3c,8'h3e,8'h3f,8'h5f,
		8'h0b,8'h1f,8'h1d,8'h08,8'h00,8'h00,8'h00,8'h00,
		8'h03,8'h00,8'h00,8'h00,8'h00,8'h00,8'h20,8'h1b
	};

	localparam logic [7:0] TAB_KANA [LEN_OTHER] = '{
		8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,
		8'h38,8'h39,8'h2a,8'h2b,8'h3d,8'h2c,8'h2e,8'h0d,
		8'hde,8'hc1,8'hba,8'hbf,8'hbc,8'hb2,8'hca,8'hb7,
		8'hb8,8'hc6,8'hcf,8'hc9,8'hd8,8'hd3,8'hd0,8'hd7,
		8'hbe,8'hc0,8'hbd,8'hc4,8'hb6,8'hc5,8'hcb,8'hc3,
		8'hbb,8'hdd,8'hc2,8'hdf,8'hb0,8'hd1,8'hcd,8'hce,
		8'hdc,8'hc7,8'hcc,8'hb1,8'hb3,8'hb4,8'hb5,8'hd4,
		8'hd5,8'hd6,8'hb9,8'hda,8'hc8,8'hd9,8'hd2,8'hdb,
		8'h0c,8'h1e,8'h1c,8'h08,8'h00,8'h00,8'h00,8'h00,
		8'h03,8'h00,8'h00,8'h00,8'h00,8'h00,8'h20,8'h1b
	};

	localparam logic [7:0] TAB_KANA_SHIFT [LEN_OTHER] = '{
		8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,
		8'h38,8'h39,8'h2a,8'h2b,8'h3d,8'h2c,8'h2e,8'h0d,
		8'hde,8'hc1,8'hba,8'hbf,8'hbc,8'hb2,8'hca,8'hb7,
		8'hb8,8'hc6,8'hcf,8'hc9,8'hd8,8'hd3,8'hd0,8'hd7,
		8'hbe,8'hc0,8'hbd,8'hc4,8'hb6,8'hc5,8'hcb,8'hc3,
		8'hbb,8'hdd,8'haf,8'hdf,8'hb0,8'hd1,8'hcd,8'hce,
		8'ha6,8'hc7,8'hcc,8'ha7,8'ha9,8'haa,8'hab,8'hac,
		8'had,8'hae,8'hb9,8'hda,8'hc8,8'hd9,8'hd2,8'hdb,
		8'h0c,8'h1e,8'h1c,8'h08,8'h00,8'h00,8'h00,8'h00,
		8'h03,8'h00,8'h00,8'h00,8'h00,8'h00,8'h20,8'h1b
	};

	localparam logic [7:0] TAB_GRAPH [LEN_GRAPH] = '{
		8'h9a,8'h93,8'h8f,8'h92,8'he1,8'he2,8'he3,8'h98,
		8'h91,8'h99,8'h95,8'he0,8'h96,8'h90,8'h9b,8'h96,
		8'h8a,8'h9e,8'h84,8'h82,8'he6,8'he4,8'he7,8'hec,
		8'hed,8'he8,8'hea,8'heb,8'h8e,8'h86,8'h85,8'he9,
		8'h8d,8'h9c,8'he5,8'h9f,8'hee,8'hf0,8'h83,8'h9d,
		8'h81,8'hef,8'h80,8'h00,8'hf1,8'h00,8'h8b,8'h8c,
		8'hf7,8'h00,8'h00,8'h00,8'h00,8'hf2,8'hf3,8'hf4,
		8'hf5,8'hf6,8'h94,8'h89,8'h87,8'h88,8'h97,8'h00
	};

	// Code for a matrix position under a modifier; past a table's end gives 0
	function automatic logic [7:0] code_lookup(input logic [2:0] mode, input logic [6:0] idx);
		logic [7:0] c;
		c = 8'h00;
		if (mode[2]) begin
			if (idx < 7'(LEN_GRAPH)) c = TAB_GRAPH[idx[5:0]];
		end else begin
			unique case (mode[1:0])
				MODE_NORMAL:     if (idx < 7'(LEN_NORMAL)) c = TAB_NORMAL[idx];
				MODE_SHIFT:      if (idx < 7'(LEN_OTHER)) c = TAB_SHIFT[idx];
				MODE_KANA:       if (idx < 7'(LEN_OTHER)) c = TAB_KANA[idx];
				MODE_KANA_SHIFT: if (idx < 7'(LEN_OTHER)) c = TAB_KANA_SHIFT[idx];
				default:         c = 8'h00;
			endcase
		end
		return c;
	endfunction

endpackage

// File: rtl/kmq_row_if.sv
// Input channel: one keyboard matrix row per transaction.
// No dependencies.
interface kmq_row_if;
	logic       valid;
	logic       ready;
	logic [3:0] row_index;
	logic [7:0] row_bits;
	logic [2:0] modifier_bits;

	modport source(output valid, row_index, row_bits, modifier_bits, input ready);
	modport sink(input valid, row_index, row_bits, modifier_bits, output ready);
endinterface

// File: rtl/kmq_key_if.sv
// Output channel: one key code per transaction.
// No dependencies.
interface kmq_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_code;

	modport source(output valid, key_code, input ready);
	modport sink(input valid, key_code, output ready);
endinterface

// File: rtl/kmq_ring.sv
// Key ring: small FIFO of key codes with clear, push and pop commands.
// Depends on kmq_pkg.
module kmq_ring import kmq_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ring_cmd_t                  cmd,
	output logic [7:0]                 head_code,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [7:0]    mem_q [DEPTH];
	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH-1)) ? '0 : p + 1'b1;
	endfunction

	// Storage, written at the tail
	always_ff @(posedge clk) begin
		if (cmd.push && !cmd.clear) mem_q[tail_q] <= cmd.data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.push) begin
			tail_q  <= ptr_next(tail_q);
			count_q <= count_q + 1'b1;
		end else if (cmd.pop) begin
			head_q  <= ptr_next(head_q);
			count_q <= count_q - 1'b1;
		end
	end

	assign head_code = mem_q[head_q];
	assign count     = count_q;
endmodule

// File: rtl/keyboard_matrix_key_queue.sv
// Top level of the keyboard matrix key queue: row sequencer and output register.
// Depends on kmq_pkg, kmq_row_if, kmq_key_if and kmq_ring.
//
// Usage: the scanner hands over one matrix row per transaction on rows
// (row_index, active-low row_bits, modifier_bits). Modifiers are sampled on
// row 0; a change empties the key ring and switches the code table. Newly
// pressed keys queue their codes (lowest bit first) until the ring is full;
// released keys drop matching codes from the head. After the last row one
// key_code leaves on keys: the head code, or 0 when nothing is queued.
// Rows at or past ROW_COUNT are taken and ignored.
// Steps: a row passes through one capture, one modifier/edge step, eight press
// steps and eight release steps before the next row is accepted. Each released
// key with a nonzero code adds a drop step that pops matching codes from the
// head one by one, and the last row adds an emit step for its result. The walk
// is per bit through the shared table lookup and ring port. The result sits in
// an output register; while the receiver stalls, the block finishes the next
// rows and only waits once it must write a second result. Reset empties the
// ring, clears the modifier and marks all keys released.
module keyboard_matrix_key_queue import kmq_pkg::*; #(
	parameter int RING_DEPTH = 4,
	parameter int ROW_COUNT  = 11
) (
	input  logic     clk,
	input  logic     arst_n,
	kmq_row_if.sink  rows,
	kmq_key_if.source keys
);
	localparam int RW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int CW = $clog2(RING_DEPTH+1);
	localparam logic [3:0] LAST_ROW = 4'(ROW_COUNT-1);

	seq_state_t    state_q;
	logic [3:0]    row_q;
	logic [7:0]    bits_q;
	logic [2:0]    mods_q;
	logic [2:0]    mode_q;
	logic [7:0]    pressed_q, released_q;
	logic [2:0]    bit_q;
	logic [7:0]    prev_q [ROW_COUNT];
	logic [7:0]    key_q;
	logic          key_valid_q;

	ring_cmd_t     cmd;
	logic [7:0]    head_code;
	logic [CW-1:0] count;
	logic [7:0]    code_now;
	logic [7:0]    prev_row;
	logic          ring_full, slot_free;

	kmq_ring #(.DEPTH(RING_DEPTH)) u_ring (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .head_code(head_code), .count(count)
	);

	// Shared table lookup for the current row and bit
	assign code_now  = code_lookup(mode_q, {row_q, bit_q});
	assign prev_row  = prev_q[row_q[RW-1:0]];
	assign ring_full = (count == CW'(RING_DEPTH));
	assign slot_free = !key_valid_q || keys.ready;

	// Ring commands
	always_comb begin
		cmd = '{clear: 1'b0, push: 1'b0, pop: 1'b0, data: code_now};
		unique case (state_q)
			ST_MODE:  cmd.clear = (row_q == 4'd0) && (mods_q != mode_q);
			ST_PRESS: cmd.push  = pressed_q[bit_q] && !ring_full && (code_now != 8'h00);
			ST_DROP:  cmd.pop   = (count != '0) && (head_code == code_now);
			ST_EMIT:  cmd.pop   = slot_free && (count > CW'(1));
			default:  ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= '0;
			bit_q      <= '0;
			row_q      <= '0;
			bits_q     <= '0;
			mods_q     <= '0;
			pressed_q  <= '0;
			released_q <= '0;
			for (int i = 0; i < ROW_COUNT; i++) prev_q[i] <= 8'hff;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (rows.valid) begin
						row_q   <= rows.row_index;
						bits_q  <= rows.row_bits;
						mods_q  <= rows.modifier_bits;
						state_q <= ({1'b0, rows.row_index} < 5'(ROW_COUNT)) ? ST_MODE : ST_IDLE;
					end
				end
				ST_MODE: begin
					if (cmd.clear) mode_q <= mods_q;
					pressed_q  <= ~bits_q & prev_row;
					released_q <= bits_q & ~prev_row;
					prev_q[row_q[RW-1:0]] <= bits_q;
					bit_q   <= '0;
					state_q <= ST_PRESS;
				end
				ST_PRESS: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == 3'd7) state_q <= ST_REL;
				end
				ST_REL, ST_DROP: begin
					if (state_q == ST_REL && released_q[bit_q] && code_now != 8'h00) begin
						state_q <= ST_DROP;
					end else if (state_q == ST_DROP && cmd.pop) begin
						state_q <= ST_DROP;
					end else if (bit_q == 3'd7) begin
						state_q <= (row_q == LAST_ROW) ? ST_EMIT : ST_IDLE;
					end else begin
						bit_q   <= bit_q + 1'b1;
						state_q <= ST_REL;
					end
				end
				ST_EMIT: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: a new result wins over the hand-off of the old one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && slot_free) key_valid_q <= 1'b1;
			else if (keys.ready) key_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && slot_free) key_q <= (count == '0) ? 8'h00 : head_code;
	end

	assign rows.ready    = (state_q == ST_IDLE);
	assign keys.valid    = key_valid_q;
	assign keys.key_code = key_q;
endmodule

// File: bench/tb_top.sv
// Self-checking bench for keyboard_matrix_key_queue: rows go in on one channel, key codes come out
// on the other, and each code is checked against an in-bench prediction of the key ring.
// Depends on kmq_pkg, kmq_row_if, kmq_key_if and the block itself.
module tb_top import kmq_pkg::*;;

	localparam int NUM_ROWS   = 11;
	localparam int RING_SLOTS = 4;

	typedef struct {
		logic [3:0] row;
		logic [7:0] bits;
		logic [2:0] mods;
		bit         drain_first;
	} row_item_t;

	logic clk;
	logic arst_n;

	kmq_row_if rows_if();
	kmq_key_if keys_if();

	keyboard_matrix_key_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rows   (rows_if.sink),
		.keys   (keys_if.source)
	);

	// Stimulus and expectation stores
	row_item_t  rows_pending[$];
	logic [7:0] codes_expected[$];
	int         errors;

	// Predicted block state
	logic [7:0] last_rows [NUM_ROWS];
	logic [2:0] cur_mode;
	logic [7:0] ring_codes[$];

	// Random scan state
	logic [7:0] held_rows [NUM_ROWS];
	logic [2:0] scan_mode;

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("error: %s got %02h expected %02h", what, got, want);
		errors++;
	endtask

	// Code table lookup, past each table's end gives 0
	function automatic logic [7:0] table_code(input logic [2:0] mode, input logic [6:0] idx);
		logic [7:0] c;
		c = 8'h00;
		if (mode[2]) begin
			if (idx < 7'(LEN_GRAPH)) c = TAB_GRAPH[idx[5:0]];
		end else begin
			case (mode[1:0])
				MODE_NORMAL:     if (idx < 7'(LEN_NORMAL)) c = TAB_NORMAL[idx];
				MODE_SHIFT:      if (idx < 7'(LEN_OTHER)) c = TAB_SHIFT[idx];
				MODE_KANA:       if (idx < 7'(LEN_OTHER)) c = TAB_KANA[idx];
				default:         if (idx < 7'(LEN_OTHER)) c = TAB_KANA_SHIFT[idx];
			endcase
		end
		return c;
	endfunction

	// Advance the ring prediction by one accepted row
	task automatic predict_row(input logic [3:0] row, input logic [7:0] bits,
			input logic [2:0] mods);
		logic [7:0] pressed;
		logic [7:0] released;
		logic [7:0] c;
		if (row >= NUM_ROWS) return;
		if (row == 0 && mods != cur_mode) begin
			cur_mode = mods;
			ring_codes.delete();
		end
		pressed  = ~bits & last_rows[row];
		released = bits & ~last_rows[row];
		for (int j = 0; j < 8; j++) begin
			if (pressed[j] && ring_codes.size() < RING_SLOTS) begin
				c = table_code(cur_mode, 7'(row * 8 + j));
				if (c != 8'h00) ring_codes.push_back(c);
			end
		end
		for (int j = 0; j < 8; j++) begin
			if (released[j]) begin
				c = table_code(cur_mode, 7'(row * 8 + j));
				if (c != 8'h00)
					while (ring_codes.size() > 0 && ring_codes[0] == c) ring_codes.pop_front();
			end
		end
		last_rows[row] = bits;
		if (row != NUM_ROWS - 1) return;
		if (ring_codes.size() == 0) begin
			codes_expected.push_back(8'h00);
		end else begin
			codes_expected.push_back(ring_codes[0]);
			if (ring_codes.size() > 1) ring_codes.pop_front();
		end
	endtask

	task automatic add_row(input int row, input logic [7:0] bits, input logic [2:0] mods,
			input bit drain);
		row_item_t it;
		it.row = 4'(row);
		it.bits = bits;
		it.mods = mods;
		it.drain_first = drain;
		rows_pending.push_back(it);
	endtask

	// One full scan of random key activity, sometimes with stray rows mixed in
	task automatic add_scan();
		int flips;
		if ($urandom_range(0, 9) == 0) scan_mode = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 14) == 0)
			foreach (held_rows[r]) held_rows[r] = 8'hff;
		for (int r = 0; r < NUM_ROWS; r++) begin
			flips = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			for (int f = 0; f < flips; f++)
				held_rows[r][$urandom_range(0, 7)] ^= 1'b1;
			if ($urandom_range(0, 39) == 0) held_rows[r] = 8'($urandom);
			add_row(r, held_rows[r], (r == 0) ? scan_mode : 3'($urandom), 1'b0);
			if ($urandom_range(0, 29) == 0)
				add_row($urandom_range(0, 15), 8'($urandom), 3'($urandom), 1'b0);
		end
	endtask

	// Row driver: bursts of transactions with random gaps
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_if.valid         <= 1'b0;
			rows_if.row_index     <= '0;
			rows_if.row_bits      <= 8'hff;
			rows_if.modifier_bits <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (rows_if.valid && rows_if.ready)
				predict_row(rows_if.row_index, rows_if.row_bits, rows_if.modifier_bits);
			if (!rows_if.valid || rows_if.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					rows_if.valid <= 1'b0;
				end else if (rows_pending.size() > 0 &&
						!(rows_pending[0].drain_first && codes_expected.size() > 0)) begin
					rows_if.valid         <= 1'b1;
					rows_if.row_index     <= rows_pending[0].row;
					rows_if.row_bits      <= rows_pending[0].bits;
					rows_if.modifier_bits <= rows_pending[0].mods;
					void'(rows_pending.pop_front());
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					rows_if.valid <= 1'b0;
				end
			end
		end
	end

	// Key monitor: checks each transaction, stalls on its own pattern
	int stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_if.ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			if (keys_if.valid && keys_if.ready) begin
				if (codes_expected.size() == 0)
					report("unexpected key_code", keys_if.key_code, 8'h00);
				else begin
					if (keys_if.key_code !== codes_expected[0])
						report("key_code", keys_if.key_code, codes_expected[0]);
					void'(codes_expected.pop_front());
				end
			end
			stall_phase <= (stall_phase + 1) % 97;
			if (stall_phase < 30)
				keys_if.ready <= 1'b1;
			else if (stall_phase < 60)
				keys_if.ready <= ($urandom_range(0, 2) != 0);
			else
				keys_if.ready <= ($urandom_range(0, 4) == 0);
		end
	end

	// Stimulus and end of run
	initial begin
		errors = 0;
		cur_mode = '0;
		scan_mode = '0;
		foreach (last_rows[r]) last_rows[r] = 8'hff;
		foreach (held_rows[r]) held_rows[r] = 8'hff;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty ring, table ends, full ring, ignored rows, several modes
		add_row(10, 8'hff, 3'd0, 1'b0);
		add_row(10, 8'h00, 3'd0, 1'b0);
		add_row(10, 8'hff, 3'd0, 1'b0);
		add_row(0, 8'h00, 3'd0, 1'b0);
		add_row(11, 8'h00, 3'd5, 1'b0);
		add_row(15, 8'h00, 3'd7, 1'b0);
		add_row(10, 8'hff, 3'd0, 1'b0);
		add_row(0, 8'hff, 3'd0, 1'b0);
		add_row(0, 8'h00, 3'd7, 1'b0);
		add_row(7, 8'h00, 3'd0, 1'b0);
		add_row(10, 8'h00, 3'd0, 1'b0);
		add_row(0, 8'hff, 3'd3, 1'b1);
		add_row(5, 8'h00, 3'd0, 1'b0);
		add_row(5, 8'h55, 3'd0, 1'b0);
		add_row(10, 8'hff, 3'd0, 1'b0);
		add_row(0, 8'hff, 3'd1, 1'b0);
		add_row(4, 8'h0f, 3'd0, 1'b0);
		add_row(4, 8'hff, 3'd0, 1'b0);
		add_row(10, 8'hff, 3'd0, 1'b0);
		add_row(0, 8'hfe, 3'd2, 1'b0);
		add_row(10, 8'h7f, 3'd0, 1'b0);
		add_row(0, 8'hff, 3'd4, 1'b0);
		add_row(9, 8'h00, 3'd0, 1'b0);
		add_row(10, 8'hff, 3'd0, 1'b0);

		// Random scans, one pause for a full drain halfway
		for (int s = 0; s < 140; s++) begin
			if (s == 70) add_row(0, held_rows[0], scan_mode, 1'b1);
			add_scan();
		end

		while (rows_pending.size() > 0 || rows_if.valid) @(posedge clk);
		while (codes_expected.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("keyboard_matrix_key_queue: match");
		else
			$display("keyboard_matrix_key_queue: mismatch");
		$finish;
	end

	initial begin
		#8000000;
		$display("keyboard_matrix_key_queue: mismatch");
		$finish;
	end

endmodule
